// ----- rtl/tcf_pkg.sv -----
// Shared types and byte codes for the telnet command filter.
// Used by the parser and the top level.
`default_nettype none

package tcf_pkg;

   localparam logic [7:0] BYTE_IAC  = 8'hFF;
   localparam logic [7:0] BYTE_SB   = 8'hFA;
   localparam logic [7:0] BYTE_SE   = 8'hF0;
   localparam logic [7:0] BYTE_WILL = 8'hFB;
   localparam logic [7:0] BYTE_DO   = 8'hFD;
   localparam logic [7:0] BYTE_DONT = 8'hFE;
   localparam logic [7:0] OPT_NAWS  = 8'h1F;
   localparam logic [7:0] OPT_SGA   = 8'h03;
   localparam logic [7:0] CTRL_C    = 8'h03;
   localparam logic [7:0] CTRL_D    = 8'h04;

   localparam int unsigned SUB_COUNT_W   = 3;
   localparam logic [SUB_COUNT_W-1:0] SUB_BYTES_NAWS = 3'd4;
   localparam logic [SUB_COUNT_W-1:0] SUB_COUNT_MAX  = 3'd5;

   typedef enum logic [2:0] {
      MODE_DATA   = 3'd0,
      MODE_IAC    = 3'd1,
      MODE_OPT    = 3'd2,
      MODE_SBCODE = 3'd3,
      MODE_SBDATA = 3'd4,
      MODE_SBIAC  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        clear_line;
      logic        close_request;
      logic        window_update;
      logic [15:0] window_width;
      logic [15:0] window_height;
      logic        suppress_goahead;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/tcf_if.sv -----
// Valid/ready channel interfaces for the telnet command filter.
// Request carries one stream byte per item, response one filtered result.
`default_nettype none

interface tcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_message;

   modport source (output valid, output in_byte, output end_of_message, input ready);
   modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface tcf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_valid;
   logic        clear_line;
   logic        close_request;
   logic        window_update;
   logic [15:0] window_width;
   logic [15:0] window_height;
   logic        suppress_goahead;

   modport source (output valid, output out_byte, output out_valid, output clear_line,
                   output close_request, output window_update, output window_width,
                   output window_height, output suppress_goahead, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input clear_line,
                   input close_request, input window_update, input window_width,
                   input window_height, input suppress_goahead, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcf_parser.sv -----
// Telnet IAC parser state and per-byte next-state logic.
// Depends on tcf_pkg for byte codes, mode enum and item structs.
`default_nettype none

module tcf_parser import tcf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      res
);

   mode_type                 mode_ff,    mode_in;
   logic [7:0]               pending_ff, pending_in;
   logic [7:0]               code_ff,    code_in;
   logic [SUB_COUNT_W-1:0]   count_ff,   count_in;
   logic [31:0]              capture_ff, capture_in;
   logic                     skip_ff,    skip_in;
   logic                     sga_ff,     sga_in;
   logic [15:0]              width_ff,   width_in;
   logic [15:0]              height_ff,  height_in;

   logic [7:0] b;
   logic       sub_capture;
   logic       plain_data;

   assign b = req.in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DATA;
         pending_ff <= '0;
         code_ff    <= '0;
         count_ff   <= '0;
         capture_ff <= '0;
         skip_ff    <= 1'b0;
         sga_ff     <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         code_ff    <= code_in;
         count_ff   <= count_in;
         capture_ff <= capture_in;
         skip_ff    <= skip_in;
         sga_ff     <= sga_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pending_in  = pending_ff;
      code_in     = code_ff;
      count_in    = count_ff;
      capture_in  = capture_ff;
      skip_in     = skip_ff;
      sga_in      = sga_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      sub_capture = 1'b0;
      plain_data  = 1'b0;
      res         = '0;

      if (!skip_ff) begin
         unique case (mode_ff)
            MODE_IAC: begin
               if (b == BYTE_IAC) begin
                  res.out_byte  = BYTE_IAC;
                  res.out_valid = 1'b1;
                  mode_in       = MODE_DATA;
               end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
                  pending_in = b;
                  mode_in    = MODE_OPT;
               end else if (b == BYTE_SB) begin
                  mode_in = MODE_SBCODE;
               end else begin
                  plain_data = 1'b1;
               end
            end
            MODE_OPT: begin
               if (pending_ff == BYTE_DO && b == OPT_SGA) begin
                  sga_in = 1'b1;
               end
               mode_in = MODE_DATA;
            end
            MODE_SBCODE: begin
               code_in    = b;
               count_in   = '0;
               capture_in = '0;
               mode_in    = (b == BYTE_IAC) ? MODE_SBIAC : MODE_SBDATA;
            end
            MODE_SBDATA: begin
               if (b == BYTE_IAC) begin
                  mode_in = MODE_SBIAC;
               end else begin
                  sub_capture = 1'b1;
               end
            end
            MODE_SBIAC: begin
               if (b == BYTE_IAC) begin
                  sub_capture = 1'b1;
                  mode_in     = MODE_SBDATA;
               end else begin
                  if (b == BYTE_SE && code_ff == OPT_NAWS && count_ff == SUB_BYTES_NAWS) begin
                     width_in          = capture_ff[31:16];
                     height_in         = capture_ff[15:0];
                     res.window_update = 1'b1;
                  end
                  mode_in = MODE_DATA;
               end
            end
            default: begin
               if (b == BYTE_IAC) begin
                  mode_in = MODE_IAC;
               end else begin
                  plain_data = 1'b1;
               end
            end
         endcase
      end

      if (sub_capture) begin
         if (count_ff < SUB_BYTES_NAWS) begin
            capture_in = {capture_ff[23:0], b};
         end
         if (count_ff < SUB_COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (plain_data) begin
         mode_in = MODE_DATA;
         priority if (b == CTRL_C) begin
            res.clear_line = 1'b1;
            skip_in        = 1'b1;
         end else if (b == CTRL_D) begin
            res.close_request = 1'b1;
            skip_in           = 1'b1;
         end else begin
            res.out_byte  = b;
            res.out_valid = 1'b1;
         end
      end

      if (req.end_of_message) begin
         mode_in = MODE_DATA;
         skip_in = 1'b0;
      end

      res.window_width     = width_in;
      res.window_height    = height_in;
      res.suppress_goahead = sga_in;
   end

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> !res.out_valid && !res.clear_line && !res.close_request
                  && !res.window_update)
      else $error("tcf_parser: output while dropping rest of message");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SUB_COUNT_MAX)
      else $error("tcf_parser: sub-option count out of range");

   a_update_load: assert property (@(posedge clock) disable iff (reset)
      step_en && res.window_update |=> width_ff == $past(capture_ff[31:16])
                                       && height_ff == $past(capture_ff[15:0]))
      else $error("tcf_parser: window size not loaded from capture");

   a_eom_resets: assert property (@(posedge clock) disable iff (reset)
      step_en && req.end_of_message |=> mode_ff == MODE_DATA && !skip_ff)
      else $error("tcf_parser: message end did not return to data mode");

endmodule

`default_nettype wire

// ----- rtl/telnet_command_filter_unit.sv -----
// An accepted item passes the input register, then the result register, which offers its result.
// One item per cycle absent stalls; the input register advances whenever the result slot frees.
// Each item yields exactly one result; parser state updates as the item leaves the input stage.
// Reset (synchronous, active high) empties both stages and returns the parser to data mode
// with window size, go-ahead flag and sub-option capture cleared.
`default_nettype none

module telnet_command_filter_unit import tcf_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   tcf_req_if.sink    req_chan,
   tcf_rsp_if.source  rsp_chan
);

   logic    in_vld_ff;
   req_type in_ff;
   logic    rsp_vld_ff;
   rsp_type rsp_ff;
   rsp_type parse_res;
   logic    advance;
   logic    take;

   assign advance        = in_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.in_byte        <= req_chan.in_byte;
         in_ff.end_of_message <= req_chan.end_of_message;
      end
   end

   tcf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_ff),
      .res     (parse_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= parse_res;
      end
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.out_byte         = rsp_ff.out_byte;
   assign rsp_chan.out_valid        = rsp_ff.out_valid;
   assign rsp_chan.clear_line       = rsp_ff.clear_line;
   assign rsp_chan.close_request    = rsp_ff.close_request;
   assign rsp_chan.window_update    = rsp_ff.window_update;
   assign rsp_chan.window_width     = rsp_ff.window_width;
   assign rsp_chan.window_height    = rsp_ff.window_height;
   assign rsp_chan.suppress_goahead = rsp_ff.suppress_goahead;

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_ff))
      else $error("telnet_command_filter_unit: stalled item lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_chan.ready |-> !advance)
      else $error("telnet_command_filter_unit: result overwritten while stalled");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("telnet_command_filter_unit: advanced item produced no result");

endmodule

`default_nettype wire
